// File: design/dsmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsmt_pkg
// Shared types and constants for the debounced start and match timer block.
// ----------------------------------------------------------------------------
package dsmt_pkg;

    localparam int unsigned COUNTDOWN_WIDTH_DEF = 16;

    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned LIMIT_W   = 8;
    localparam int unsigned LENGTH_W  = 20;
    localparam int unsigned ELAPSED_W = LENGTH_W + 1;
    localparam int unsigned LOAD_W    = 16;
    localparam int unsigned LEFT_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = LENGTH_W;

    localparam logic [LIMIT_W-1:0]  RESET_DEBOUNCE_LIMIT = 8'd30;
    localparam logic [LENGTH_W-1:0] RESET_MATCH_LENGTH   = 20'd90000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_LOAD_SEQ  = 2'd1,
        FUNC_LOAD_DLY  = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_LIMIT = 1'd0,
        CFG_MATCH_LENGTH   = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              pin_level;
        logic [LOAD_W-1:0] load_value;
    } t_item;

    typedef struct packed {
        logic              start_event;
        logic              end_event;
        logic              match_over;
        logic              motors_free;
        logic              armed;
        logic [LEFT_W-1:0] sequence_left;
        logic [LEFT_W-1:0] delay_left;
    } t_result;

endpackage
`default_nettype wire

// File: design/dsmt_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsmt_core
// Debounce integrator, arming logic, run timer and two countdowns. Holds the
// block state and forms the result for the item presented this cycle.
// ----------------------------------------------------------------------------
module dsmt_core
    import dsmt_pkg::*;
#(
    parameter int unsigned COUNTDOWN_WIDTH = COUNTDOWN_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_advance,
    input  wire t_item               i_item,
    input  wire logic [LIMIT_W-1:0]  i_debounce_limit,
    input  wire logic [LENGTH_W-1:0] i_match_length,
    output t_result                  o_result
);

    logic [LIMIT_W-1:0]         r_integ,   n_integ;
    logic                       r_armed,   n_armed;
    logic                       r_active,  n_active;
    logic [ELAPSED_W-1:0]       r_elapsed, n_elapsed;
    logic                       r_over,    n_over;
    logic [COUNTDOWN_WIDTH-1:0] r_seq,     n_seq;
    logic [COUNTDOWN_WIDTH-1:0] r_dly,     n_dly;

    logic [COUNTDOWN_WIDTH-1:0] load_cd;
    logic [ELAPSED_W-1:0]       len_ext;
    logic [ELAPSED_W-1:0]       el_mid;
    logic                       act_mid;
    logic                       start_ev, end_ev, free_mot;

    assign load_cd = COUNTDOWN_WIDTH'(i_item.load_value);
    assign len_ext = ELAPSED_W'(i_match_length);

    always_comb begin
        n_integ   = r_integ;
        n_armed   = r_armed;
        n_active  = r_active;
        n_elapsed = r_elapsed;
        n_over    = r_over;
        n_seq     = r_seq;
        n_dly     = r_dly;
        el_mid    = r_elapsed;
        act_mid   = r_active;
        start_ev  = 1'b0;
        end_ev    = 1'b0;
        free_mot  = 1'b0;

        unique case (i_item.func)
            FUNC_LOAD_SEQ: n_seq = load_cd;
            FUNC_LOAD_DLY: n_dly = load_cd;
            FUNC_TICK: begin
                // saturating integrator
                if (i_item.pin_level) begin
                    if (r_integ < i_debounce_limit) begin
                        n_integ = r_integ + LIMIT_W'(1);
                    end
                end else if (r_integ != '0) begin
                    n_integ = r_integ - LIMIT_W'(1);
                end

                if (r_armed) begin
                    if (n_integ == '0) begin
                        n_armed  = 1'b0;
                        act_mid  = 1'b1;
                        el_mid   = '0;
                        start_ev = 1'b1;
                    end
                end else if (n_integ == i_debounce_limit) begin
                    n_armed = 1'b1;
                    act_mid = 1'b0;
                    el_mid  = '0;
                end
                n_active = act_mid;

                if (r_dly != '0) begin
                    n_dly = r_dly - COUNTDOWN_WIDTH'(1);
                end
                if (r_seq != '0) begin
                    n_seq = r_seq - COUNTDOWN_WIDTH'(1);
                end

                if (el_mid < len_ext) begin
                    n_elapsed = act_mid ? el_mid + ELAPSED_W'(1) : '0;
                    n_over    = 1'b0;
                end else if (el_mid == len_ext) begin
                    n_elapsed = el_mid + ELAPSED_W'(1);
                    end_ev    = 1'b1;
                    n_over    = 1'b1;
                end else begin
                    // past the end: hold while running, clear when stopped
                    free_mot  = 1'b1;
                    n_over    = 1'b1;
                    n_elapsed = act_mid ? el_mid : '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.start_event   = start_ev;
        o_result.end_event     = end_ev;
        o_result.match_over    = n_over;
        o_result.motors_free   = free_mot;
        o_result.armed         = n_armed;
        o_result.sequence_left = LEFT_W'(n_seq);
        o_result.delay_left    = LEFT_W'(n_dly);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ   <= '0;
            r_armed   <= 1'b0;
            r_active  <= 1'b0;
            r_elapsed <= '0;
            r_over    <= 1'b0;
            r_seq     <= '0;
            r_dly     <= '0;
        end else if (i_advance) begin
            r_integ   <= n_integ;
            r_armed   <= n_armed;
            r_active  <= n_active;
            r_elapsed <= n_elapsed;
            r_over    <= n_over;
            r_seq     <= n_seq;
            r_dly     <= n_dly;
        end
    end

endmodule
`default_nettype wire

// File: design/debounced_start_match_timer.sv
`default_nettype none
// an accepted item passes the input register, then the result register, before
// its result shows; one item is accepted every cycle when the output side does
// not stall. the state update is a single pass of short logic.
// synchronous active-low reset clears the block state and the pipeline valid
// flags; config registers return to debounce limit 30 and match length 90000.
// ----------------------------------------------------------------------------
// debounced_start_match_timer
// Start-cord debouncer with match run timer and two countdowns, with an input
// register, a one-pass update and a result register.
// ----------------------------------------------------------------------------
module debounced_start_match_timer
    import dsmt_pkg::*;
#(
    parameter int unsigned COUNTDOWN_WIDTH = COUNTDOWN_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic                  i_pin_level,
    input  wire logic [LOAD_W-1:0]     i_load_value,

    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_start_event,
    output logic                       o_end_event,
    output logic                       o_match_over,
    output logic                       o_motors_free,
    output logic                       o_armed,
    output logic [LEFT_W-1:0]          o_sequence_left,
    output logic [LEFT_W-1:0]          o_delay_left
);

    logic [LIMIT_W-1:0]  r_debounce_limit;
    logic [LENGTH_W-1:0] r_match_length;
    logic                r_in_valid;
    t_item               r_item;
    logic                r_out_valid;
    t_result             r_result;
    t_result             core_result;
    logic                advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit <= RESET_DEBOUNCE_LIMIT;
            r_match_length   <= RESET_MATCH_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE_LIMIT: r_debounce_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_MATCH_LENGTH:   r_match_length   <= i_cfg_data[LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    // item moves on when the result register is empty or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item.func       <= i_func;
            r_item.pin_level  <= i_pin_level;
            r_item.load_value <= i_load_value;
        end
    end

    dsmt_core #(
        .COUNTDOWN_WIDTH (COUNTDOWN_WIDTH)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_item           (r_item),
        .i_debounce_limit (r_debounce_limit),
        .i_match_length   (r_match_length),
        .o_result         (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_start_event   = r_result.start_event;
    assign o_end_event     = r_result.end_event;
    assign o_match_over    = r_result.match_over;
    assign o_motors_free   = r_result.motors_free;
    assign o_armed         = r_result.armed;
    assign o_sequence_left = r_result.sequence_left;
    assign o_delay_left    = r_result.delay_left;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for debounced_start_match_timer. A queue of pending
// items feeds a clocked driver, a clocked monitor compares every result with
// a cycle-free model of the cord integrator, run timer and countdowns, and
// the run steps through several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import dsmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FUNC_SPARE  = 2'd3;
    localparam int unsigned       CYCLE_LIMIT = 100000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    t_cfg_idx              cfg_index = CFG_DEBOUNCE_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_item                 cmd = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  start_event;
    logic                  end_event;
    logic                  match_over;
    logic                  motors_free;
    logic                  armed;
    logic [LEFT_W-1:0]     sequence_left;
    logic [LEFT_W-1:0]     delay_left;

    // model state and register copies
    logic [LIMIT_W-1:0]   lim = RESET_DEBOUNCE_LIMIT;
    logic [LENGTH_W-1:0]  mlen = RESET_MATCH_LENGTH;
    logic [LIMIT_W-1:0]   integ = '0;
    logic                 armed_q = 1'b0;
    logic                 run_active = 1'b0;
    logic [ELAPSED_W-1:0] elapsed = '0;
    logic                 over_q = 1'b0;
    logic [LEFT_W-1:0]    seq_cd = '0;
    logic [LEFT_W-1:0]    dly_cd = '0;

    t_item       cmd_queue[$];
    t_result     status_queue[$];
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned queued_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;

    debounced_start_match_timer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_func          (cmd.func),
        .i_pin_level     (cmd.pin_level),
        .i_load_value    (cmd.load_value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_start_event   (start_event),
        .o_end_event     (end_event),
        .o_match_over    (match_over),
        .o_motors_free   (motors_free),
        .o_armed         (armed),
        .o_sequence_left (sequence_left),
        .o_delay_left    (delay_left)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one item applied to the model, returns the status it should produce
    function automatic t_result advance_timer(t_item it);
        t_result r;
        r = '0;
        case (it.func)
            FUNC_LOAD_SEQ: seq_cd = it.load_value;
            FUNC_LOAD_DLY: dly_cd = it.load_value;
            FUNC_TICK: begin
                if (it.pin_level) begin
                    if (integ < lim)
                        integ = integ + 1'b1;
                end else if (integ != '0) begin
                    integ = integ - 1'b1;
                end
                if (armed_q) begin
                    if (integ == '0) begin
                        armed_q = 1'b0;
                        run_active = 1'b1;
                        elapsed = '0;
                        r.start_event = 1'b1;
                    end
                end else if (integ == lim) begin
                    armed_q = 1'b1;
                    run_active = 1'b0;
                    elapsed = '0;
                end
                if (dly_cd != '0)
                    dly_cd = dly_cd - 1'b1;
                if (seq_cd != '0)
                    seq_cd = seq_cd - 1'b1;
                if (elapsed < {1'b0, mlen}) begin
                    elapsed = run_active ? elapsed + 1'b1 : '0;
                    over_q = 1'b0;
                end else if (elapsed == {1'b0, mlen}) begin
                    elapsed = elapsed + 1'b1;
                    r.end_event = 1'b1;
                    over_q = 1'b1;
                end else begin
                    r.motors_free = 1'b1;
                    over_q = 1'b1;
                    if (!run_active)
                        elapsed = '0;
                end
            end
            default: ;
        endcase
        r.match_over = over_q;
        r.armed = armed_q;
        r.sequence_left = seq_cd;
        r.delay_left = dly_cd;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic push_item(input logic [FUNC_W-1:0] func, input logic pin,
                             input logic [LOAD_W-1:0] load);
        t_item it;
        it.func = func;
        it.pin_level = pin;
        it.load_value = load;
        cmd_queue.push_back(it);
        if (func != FUNC_SPARE)
            queued_cnt++;
    endtask

    // half small values so the countdowns reach zero and saturate
    function automatic logic [LOAD_W-1:0] rand_load();
        if ($urandom_range(1) == 0)
            return LOAD_W'($urandom_range(20));
        return LOAD_W'($urandom);
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || in_valid || status_queue.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_DEBOUNCE_LIMIT)
            lim = val[LIMIT_W-1:0];
        else
            mlen = val[LENGTH_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] new_lim,
                             input logic [LENGTH_W-1:0] new_len,
                             input int unsigned send_pct, input int unsigned hold_pct,
                             input int unsigned quota);
        int unsigned base;
        int unsigned glitch;
        int unsigned run_len;
        wait_drained();
        write_reg(CFG_DEBOUNCE_LIMIT, CFG_DATA_W'(new_lim));
        write_reg(CFG_MATCH_LENGTH, CFG_DATA_W'(new_len));
        send_idle_pct = send_pct;
        stall_pct = hold_pct;
        base = queued_cnt;
        while (queued_cnt - base < quota) begin
            if ($urandom_range(99) < 75) begin
                // cord inserted long enough to arm, pulled, then the match runs
                glitch = (lim > 32) ? 2 : 10;
                run_len = lim + lim / 4 + $urandom_range(3);
                repeat (run_len)
                    push_item(FUNC_TICK, $urandom_range(99) >= glitch, rand_load());
                run_len = lim + lim / 4 + $urandom_range(3);
                repeat (run_len)
                    push_item(FUNC_TICK, $urandom_range(99) < glitch, rand_load());
                run_len = ((mlen < 60) ? mlen : 60) + $urandom_range(8);
                repeat (run_len) begin
                    if ($urandom_range(99) < 15)
                        push_item($urandom_range(1) ? FUNC_LOAD_SEQ : FUNC_LOAD_DLY,
                                  1'($urandom_range(1)), rand_load());
                    else
                        push_item(FUNC_TICK, $urandom_range(99) < 20, rand_load());
                end
            end else begin
                repeat ($urandom_range(1, 8))
                    push_item(FUNC_W'($urandom_range(3)), 1'($urandom_range(1)),
                              rand_load());
            end
        end
    endtask

    // driver: holds a stalled item, picks the next one or idles otherwise
    always @(posedge clk) begin
        logic take_next;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take_next = 1'b1;
            if (in_valid) begin
                if (in_stall)
                    take_next = 1'b0;
                else
                    status_queue.push_back(advance_timer(cmd));
            end
            if (take_next) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd <= cmd_queue.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (status_queue.size() == 0) begin
                flag_mismatch("unexpected result", 32'd1, 32'd0);
            end else begin
                want = status_queue.pop_front();
                if (start_event !== want.start_event)
                    flag_mismatch("start_event", 32'(start_event), 32'(want.start_event));
                if (end_event !== want.end_event)
                    flag_mismatch("end_event", 32'(end_event), 32'(want.end_event));
                if (match_over !== want.match_over)
                    flag_mismatch("match_over", 32'(match_over), 32'(want.match_over));
                if (motors_free !== want.motors_free)
                    flag_mismatch("motors_free", 32'(motors_free), 32'(want.motors_free));
                if (armed !== want.armed)
                    flag_mismatch("armed", 32'(armed), 32'(want.armed));
                if (sequence_left !== want.sequence_left)
                    flag_mismatch("sequence_left", 32'(sequence_left),
                                  32'(want.sequence_left));
                if (delay_left !== want.delay_left)
                    flag_mismatch("delay_left", 32'(delay_left), 32'(want.delay_left));
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[debounced_start_match_timer] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: full loads, spare code, integrator to two
        push_item(FUNC_LOAD_SEQ, 1'b0, 16'hFFFF);
        push_item(FUNC_LOAD_DLY, 1'b1, 16'hFFFF);
        push_item(FUNC_SPARE, 1'b1, 16'hFFFF);
        push_item(FUNC_TICK, 1'b1, 16'hFFFF);
        push_item(FUNC_TICK, 1'b1, 16'h0000);

        // limit lowered under the integrator: arms only on the way down
        wait_drained();
        write_reg(CFG_DEBOUNCE_LIMIT, CFG_DATA_W'(1));
        write_reg(CFG_MATCH_LENGTH, CFG_DATA_W'(2));
        push_item(FUNC_TICK, 1'b1, 16'h0000);
        repeat (5)
            push_item(FUNC_TICK, 1'b0, 16'h0000);
        push_item(FUNC_LOAD_SEQ, 1'b1, 16'h0000);
        push_item(FUNC_LOAD_DLY, 1'b0, 16'h0003);
        push_item(FUNC_TICK, 1'b1, 16'hFFFF);
        repeat (3)
            push_item(FUNC_TICK, 1'b0, 16'hFFFF);

        // zero limit and zero match length
        wait_drained();
        write_reg(CFG_DEBOUNCE_LIMIT, '0);
        write_reg(CFG_MATCH_LENGTH, '0);
        repeat (2) begin
            push_item(FUNC_TICK, 1'b1, 16'h0000);
            push_item(FUNC_TICK, 1'b0, 16'h0000);
        end

        run_phase(8'd4, 20'd12, 0, 0, 150);
        run_phase(8'd1, 20'd1, 54, 0, 120);
        run_phase(8'd0, 20'd0, 0, 54, 80);
        run_phase(8'd7, 20'd30, 33, 33, 120);
        run_phase(8'd255, 20'd5, 33, 33, 300);
        run_phase(8'd2, 20'hFFFFF, 0, 0, 80);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("[debounced_start_match_timer] OK");
        else
            $display("[debounced_start_match_timer] ERROR");
        $finish;
    end

endmodule

// File: files.f
design/dsmt_pkg.sv
design/dsmt_core.sv
design/debounced_start_match_timer.sv
tb/tb_top.sv
